### rtl/core/qvr_pkg.sv
`default_nettype none
package qvr_pkg;

    localparam int VEC_WIDTH_DEF  = 32;
    localparam int QUAT_WIDTH_DEF = 16;

    // normalized components: signed Q1.15 plus headroom for rounding
    localparam int NORM_FRAC = 15;
    localparam int NORM_W    = NORM_FRAC + 3;
    // rotation coefficients: products of normalized parts, Q.30
    localparam int MAT_FRAC  = 2 * NORM_FRAC;
    localparam int MAT_W     = 2 * NORM_W;

    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_SCALAR = 3'd0;
    localparam logic [CFG_AW-1:0] REG_I      = 3'd1;
    localparam logic [CFG_AW-1:0] REG_J      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_K      = 3'd3;

    localparam logic signed [MAT_W-1:0] MAT_ONE = MAT_W'(1) <<< MAT_FRAC;

    typedef logic signed [MAT_W-1:0] t_coef;

    // rotation matrix, row major, plus the zero-quaternion flag
    typedef struct packed {
        t_coef [8:0] m;
        logic        deg;
    } t_rot;

endpackage
`default_nettype wire

### rtl/core/quaternion_vector_rotate_top.sv
`default_nettype none
// Quaternion vector rotation. Each item is a signed Q15.16 vector (x, y, z);
// the block returns it rotated by the unit quaternion derived from four
// configuration registers (scalar, i, j, k, signed Q2.13; reset gives the
// identity). Writing a register at index 0..3 starts a setup sequencer that
// normalizes the quaternion (sum of squares, square root one result bit per
// cycle, four restoring divides at one quotient bit per cycle) and forms a
// 3x3 Q.30 rotation matrix with one shared multiplier. Setup runs the scaling
// loop where needed, the 32-step square root and the four divides; a zero
// quaternion skips them and loads the identity matrix. o_in_ready stays low
// until setup is done, and another setup runs after reset. Writes to other
// indexes are ignored. After setup the datapath is a three-stage pipeline
// (products, row sums, round and clamp into the output register): one item
// per cycle, and a stall on the output holds each full stage that has no
// empty stage after it. A zero quaternion passes the vector unchanged and
// sets o_degenerate; a clamped component sets o_saturated.
module quaternion_vector_rotate_top #(
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [qvr_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [QUAT_WIDTH-1:0]       i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic signed [VEC_WIDTH-1:0] i_in_x,
    input  wire logic signed [VEC_WIDTH-1:0] i_in_y,
    input  wire logic signed [VEC_WIDTH-1:0] i_in_z,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [VEC_WIDTH-1:0]      o_out_x,
    output logic signed [VEC_WIDTH-1:0]      o_out_y,
    output logic signed [VEC_WIDTH-1:0]      o_out_z,
    output logic                             o_degenerate,
    output logic                             o_saturated
);
    import qvr_pkg::*;

    logic  setup_done;
    t_rot  rot;
    logic  pipe_ready;

    qvr_setup #(
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (setup_done),
        .o_rot       (rot)
    );

    // hold the input side while the matrix is being rebuilt
    qvr_pipe #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rot        (rot),
        .i_in_valid   (i_in_valid && setup_done),
        .o_in_ready   (pipe_ready),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_z       (i_in_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_degenerate (o_degenerate),
        .o_saturated  (o_saturated)
    );

    assign o_in_ready = pipe_ready && setup_done;

    // no item enters while setup is running
    a_ready_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> setup_done)
        else $error("input ready while setup is busy");

    // a write to registers 0..3 always restarts the setup
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_addr <= REG_K) |=> !o_in_ready)
        else $error("input ready right after a register write");

    // the identity path never clamps
    a_deg_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |-> !o_saturated)
        else $error("degenerate item flagged as saturated");

endmodule
`default_nettype wire

### rtl/core/qvr_setup.sv
`default_nettype none
module qvr_setup #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [qvr_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [QUAT_WIDTH-1:0]       i_cfg_wdata,
    output logic                             o_done,
    output qvr_pkg::t_rot                    o_rot
);
    import qvr_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_NORM = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_MAT  = 4'd7;

    localparam int DIV_W = 48;

    logic [3:0]                   r_state;
    logic                         r_dirty;
    logic [QUAT_WIDTH-1:0]        r_q [4];
    logic [1:0]                   r_idx;
    logic [5:0]                   r_cnt;
    logic [63:0]                  r_quarter;
    logic [2:0]                   r_odd;
    logic [63:0]                  r_t;
    logic [4:0]                   r_h;
    logic [5:0]                   r_shift;
    logic [63:0]                  r_root;
    logic [63:0]                  r_bit;
    logic [31:0]                  r_len;
    logic [31:0]                  r_rem;
    logic [DIV_W-1:0]             r_quo;
    logic signed [NORM_W-1:0]     r_n [4];
    logic signed [MAT_W-1:0]      r_prod [10];
    t_rot                         r_rot;

    logic [QUAT_WIDTH-1:0]        mag;
    logic [2*QUAT_WIDTH-1:0]      sq;
    logic [63:0]                  rb;
    logic [DIV_W-1:0]             dvd;
    logic [32:0]                  rem_sh;
    logic [32:0]                  rem_sub;
    logic                         qbit;
    logic [DIV_W-1:0]             quo_nx;
    logic signed [NORM_W-1:0]     ma;
    logic signed [NORM_W-1:0]     mb;
    logic signed [MAT_W-1:0]      prod;
    logic signed [MAT_W-1:0]      kk;

    always_comb begin
        mag     = r_q[r_idx][QUAT_WIDTH-1] ? (~r_q[r_idx] + 1'b1) : r_q[r_idx];
        sq      = (2*QUAT_WIDTH)'(mag) * (2*QUAT_WIDTH)'(mag);
        rb      = r_root + r_bit;
        dvd     = (DIV_W'(mag) << r_shift) + DIV_W'(r_len >> 1);
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_len};
        qbit    = (rem_sh >= {1'b0, r_len});
        quo_nx  = {r_quo[DIV_W-2:0], qbit};
        ma      = r_n[0];
        mb      = r_n[0];
        unique case (r_cnt[3:0])
            4'd0: begin ma = r_n[0]; mb = r_n[0]; end
            4'd1: begin ma = r_n[1]; mb = r_n[1]; end
            4'd2: begin ma = r_n[2]; mb = r_n[2]; end
            4'd3: begin ma = r_n[3]; mb = r_n[3]; end
            4'd4: begin ma = r_n[1]; mb = r_n[2]; end
            4'd5: begin ma = r_n[1]; mb = r_n[3]; end
            4'd6: begin ma = r_n[2]; mb = r_n[3]; end
            4'd7: begin ma = r_n[0]; mb = r_n[1]; end
            4'd8: begin ma = r_n[0]; mb = r_n[2]; end
            4'd9: begin ma = r_n[0]; mb = r_n[3]; end
            default: begin ma = r_n[0]; mb = r_n[0]; end
        endcase
        prod = MAT_W'(ma) * MAT_W'(mb);
        kk   = r_prod[0] - r_prod[1] - r_prod[2] - r_prod[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dirty <= 1'b1;
            r_q[0]  <= QUAT_WIDTH'(1) << (QUAT_WIDTH - 3);
            r_q[1]  <= '0;
            r_q[2]  <= '0;
            r_q[3]  <= '0;
        end else if (i_cfg_we) begin
            // restart the setup on a write to registers 0..3
            if (i_cfg_addr <= REG_K) begin
                r_q[i_cfg_addr[1:0]] <= i_cfg_wdata;
                r_dirty              <= 1'b1;
                r_state              <= ST_IDLE;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (r_dirty) begin
                        r_dirty   <= 1'b0;
                        r_idx     <= '0;
                        r_quarter <= '0;
                        r_odd     <= '0;
                        r_state   <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_quarter <= r_quarter + 64'(sq >> 2);
                    r_odd     <= r_odd + 3'(mag[0]);
                    r_idx     <= r_idx + 1'b1;
                    if (r_idx == 2'd3) r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_h    <= '0;
                    r_cnt  <= '0;
                    r_root <= '0;
                    r_bit  <= 64'd1 << 62;
                    if (r_quarter == '0 && r_odd == '0) begin
                        for (int i = 0; i < 9; i++) begin
                            r_rot.m[i] <= (i % 4 == 0) ? MAT_ONE : '0;
                        end
                        r_rot.deg <= 1'b1;
                        r_state   <= ST_IDLE;
                    end else if (r_quarter >= (64'd1 << 60)) begin
                        r_t     <= r_quarter + 64'(r_odd >> 2);
                        r_shift <= 6'(NORM_FRAC - 1);
                        r_state <= ST_SQRT;
                    end else begin
                        r_t     <= (r_quarter << 2) + 64'(r_odd);
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // scale up by four while the sum stays within 2^62
                    if (r_h != 5'd31 && r_t <= (64'd1 << 60)) begin
                        r_t <= r_t << 2;
                        r_h <= r_h + 1'b1;
                    end else begin
                        r_shift <= 6'(NORM_FRAC) + 6'(r_h);
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_t >= rb) begin
                        r_t    <= r_t - rb;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 6'd31) begin
                        r_cnt   <= '0;
                        r_idx   <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_len <= r_root[31:0];
                        r_rem <= '0;
                        r_cnt <= 6'd1;
                    end else if (r_cnt == 6'd1) begin
                        r_quo <= dvd;
                        r_rem <= '0;
                        r_cnt <= 6'd2;
                    end else begin
                        r_quo <= quo_nx;
                        r_rem <= qbit ? rem_sub[31:0] : rem_sh[31:0];
                        if (r_cnt == 6'(DIV_W + 1)) begin
                            r_n[r_idx] <= r_q[r_idx][QUAT_WIDTH-1]
                                          ? -$signed(quo_nx[NORM_W-1:0])
                                          : $signed(quo_nx[NORM_W-1:0]);
                            r_idx <= r_idx + 1'b1;
                            if (r_idx == 2'd3) begin
                                r_cnt   <= '0;
                                r_state <= ST_MUL;
                            end else begin
                                r_cnt <= 6'd1;
                            end
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod[r_cnt[3:0]] <= prod;
                    r_cnt              <= r_cnt + 1'b1;
                    if (r_cnt == 6'd9) r_state <= ST_MAT;
                end
                ST_MAT: begin
                    r_rot.m[0] <= (r_prod[1] <<< 1) + kk;
                    r_rot.m[1] <= (r_prod[4] <<< 1) - (r_prod[9] <<< 1);
                    r_rot.m[2] <= (r_prod[5] <<< 1) + (r_prod[8] <<< 1);
                    r_rot.m[3] <= (r_prod[4] <<< 1) + (r_prod[9] <<< 1);
                    r_rot.m[4] <= (r_prod[2] <<< 1) + kk;
                    r_rot.m[5] <= (r_prod[6] <<< 1) - (r_prod[7] <<< 1);
                    r_rot.m[6] <= (r_prod[5] <<< 1) - (r_prod[8] <<< 1);
                    r_rot.m[7] <= (r_prod[6] <<< 1) + (r_prod[7] <<< 1);
                    r_rot.m[8] <= (r_prod[3] <<< 1) + kk;
                    r_rot.deg  <= 1'b0;
                    r_state    <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == ST_IDLE) && !r_dirty;
    assign o_rot  = r_rot;

endmodule
`default_nettype wire

### rtl/core/qvr_pipe.sv
`default_nettype none
module qvr_pipe #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire qvr_pkg::t_rot               i_rot,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic signed [VEC_WIDTH-1:0] i_in_x,
    input  wire logic signed [VEC_WIDTH-1:0] i_in_y,
    input  wire logic signed [VEC_WIDTH-1:0] i_in_z,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [VEC_WIDTH-1:0]      o_out_x,
    output logic signed [VEC_WIDTH-1:0]      o_out_y,
    output logic signed [VEC_WIDTH-1:0]      o_out_z,
    output logic                             o_degenerate,
    output logic                             o_saturated
);
    import qvr_pkg::*;

    localparam int PW = MAT_W + VEC_WIDTH;
    localparam int SW = PW + 2;
    localparam int RW = SW - MAT_FRAC;

    localparam logic signed [SW-1:0]        ROUND = SW'(1) <<< (MAT_FRAC - 1);
    localparam logic signed [VEC_WIDTH-1:0] VMAX  = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VMIN  = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    logic                          r_v1, r_v2, r_v3;
    logic                          r_d1, r_d2, r_d3;
    logic signed [PW-1:0]          r_p1 [9];
    logic signed [SW-1:0]          r_s2 [3];
    logic signed [VEC_WIDTH-1:0]   r_o3 [3];
    logic                          r_sat3;

    logic                          rdy1, rdy2, rdy3;
    logic signed [VEC_WIDTH-1:0]   vec [3];
    logic signed [RW-1:0]          res [3];
    logic [2:0]                    ovf;

    assign rdy3 = !r_v3 || i_out_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    always_comb begin
        vec[0] = i_in_x;
        vec[1] = i_in_y;
        vec[2] = i_in_z;
        for (int r = 0; r < 3; r++) begin
            res[r] = RW'(r_s2[r] >>> MAT_FRAC);
            // fits when all bits from the output sign position up agree
            ovf[r] = !((&res[r][RW-1:VEC_WIDTH-1]) || !(|res[r][RW-1:VEC_WIDTH-1]));
        end
    end

    // stage 1: nine coefficient by component products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            for (int k = 0; k < 9; k++) begin
                r_p1[k] <= PW'($signed(i_rot.m[k])) * PW'(vec[k % 3]);
            end
            r_d1 <= i_rot.deg;
        end
    end

    // stage 2: row sums with the rounding half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            for (int r = 0; r < 3; r++) begin
                r_s2[r] <= SW'(r_p1[3*r]) + SW'(r_p1[3*r+1]) + SW'(r_p1[3*r+2]) + ROUND;
            end
            r_d2 <= r_d1;
        end
    end

    // stage 3: drop fraction, clamp, hold in the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            for (int r = 0; r < 3; r++) begin
                r_o3[r] <= ovf[r] ? (res[r][RW-1] ? VMIN : VMAX) : res[r][VEC_WIDTH-1:0];
            end
            r_sat3 <= |ovf;
            r_d3   <= r_d2;
        end
    end

    assign o_in_ready   = rdy1;
    assign o_out_valid  = r_v3;
    assign o_out_x      = r_o3[0];
    assign o_out_y      = r_o3[1];
    assign o_out_z      = r_o3[2];
    assign o_degenerate = r_d3;
    assign o_saturated  = r_sat3;

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import qvr_pkg::*;

    localparam int VW = 32;
    localparam int QW = 16;
    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd5;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 deg;
        logic                 sat;
    } t_rot_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = '0;
    logic [QW-1:0]        i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [VW-1:0] i_in_x = '0;
    logic signed [VW-1:0] i_in_y = '0;
    logic signed [VW-1:0] i_in_z = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [VW-1:0] o_out_x;
    logic signed [VW-1:0] o_out_y;
    logic signed [VW-1:0] o_out_z;
    logic                 o_degenerate;
    logic                 o_saturated;

    quaternion_vector_rotate_top #(.VEC_WIDTH(VW), .QUAT_WIDTH(QW)) dut (.*);

    // testbench copy of the quaternion registers: scalar, i, j, k
    logic signed [QW-1:0] quat_regs [4] = '{16'sd8192, 16'sd0, 16'sd0, 16'sd0};

    t_vec        pending_vecs [$];
    t_rot_result expected_rots [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Normalize the quaternion and rotate one vector, bit exact.
    function automatic t_rot_result rotate_vec(t_vec vin);
        t_rot_result         res;
        longint              qv [4];
        longint              n [4];
        longint              v [3];
        longint              vh [3];
        longint              vl [3];
        longint              m [9];
        longint              s, x, y, z, k, acc_h, acc_l, comp;
        longint unsigned     mag [4];
        longint unsigned     quarter, odd, t, len, rem, root, bitv, sq;
        int                  shift, h;
        logic                sat;
        sat = 1'b0;
        quarter = 0;
        odd = 0;
        v[0] = longint'(vin.x);
        v[1] = longint'(vin.y);
        v[2] = longint'(vin.z);
        for (int i = 0; i < 3; i++) begin
            vh[i] = v[i] >>> 24;
            vl[i] = v[i] & 64'hFF_FFFF;
        end
        for (int i = 0; i < 4; i++) begin
            qv[i] = longint'(quat_regs[i]);
            mag[i] = (qv[i] < 0) ? longint'(-qv[i]) : longint'(qv[i]);
            quarter += (mag[i] * mag[i]) >> 2;
            odd += mag[i] & 1;
        end
        // zero quaternion: pass the vector through as identity
        if (quarter == 0 && odd == 0) begin
            res.x = vin.x;
            res.y = vin.y;
            res.z = vin.z;
            res.deg = 1'b1;
            res.sat = 1'b0;
            return res;
        end
        if (quarter >= (64'd1 << 60)) begin
            t = quarter + (odd >> 2);
            shift = NORM_FRAC - 1;
        end else begin
            sq = 4 * quarter + odd;
            h = 0;
            while (h < 31 && sq <= ((64'd1 << 62) >> (2 * (h + 1))))
                h++;
            t = sq << (2 * h);
            shift = NORM_FRAC + h;
        end
        // integer square root, two bits per pass
        rem = t;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        len = root;
        for (int i = 0; i < 4; i++) begin
            comp = longint'(((mag[i] << shift) + (len >> 1)) / len);
            n[i] = (qv[i] < 0) ? -comp : comp;
        end
        s = n[0];
        x = n[1];
        y = n[2];
        z = n[3];
        k = s * s - x * x - y * y - z * z;
        m[0] = 2 * x * x + k;
        m[1] = 2 * x * y - 2 * s * z;
        m[2] = 2 * x * z + 2 * s * y;
        m[3] = 2 * y * x + 2 * s * z;
        m[4] = 2 * y * y + k;
        m[5] = 2 * y * z - 2 * s * x;
        m[6] = 2 * z * x - 2 * s * y;
        m[7] = 2 * z * y + 2 * s * x;
        m[8] = 2 * z * z + k;
        for (int r = 0; r < 3; r++) begin
            acc_h = 0;
            acc_l = 0;
            for (int c = 0; c < 3; c++) begin
                acc_h += m[3 * r + c] * vh[c];
                acc_l += m[3 * r + c] * vl[c];
            end
            acc_l += longint'(1) << (MAT_FRAC - 1);
            acc_h += acc_l >>> 24;
            comp = acc_h >>> (MAT_FRAC - 24);
            // clamp to the signed output range
            if (comp > 64'sd2147483647) begin
                comp = 64'sd2147483647;
                sat = 1'b1;
            end
            if (comp < -64'sd2147483648) begin
                comp = -64'sd2147483648;
                sat = 1'b1;
            end
            case (r)
                0: res.x = comp[VW-1:0];
                1: res.y = comp[VW-1:0];
                default: res.z = comp[VW-1:0];
            endcase
        end
        res.deg = 1'b0;
        res.sat = sat;
        return res;
    endfunction

    // Driver: present the next pending item, holding it until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_rots.push_back(rotate_vec('{i_in_x, i_in_y, i_in_z}));
            if (!i_in_valid || o_in_ready) begin
                if (pending_vecs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_vec nxt;
                    nxt = pending_vecs.pop_front();
                    i_in_x <= nxt.x;
                    i_in_y <= nxt.y;
                    i_in_z <= nxt.z;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_out_valid && i_out_ready) begin
                if (expected_rots.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                             o_out_x, o_out_y, o_out_z);
                    error_count++;
                end else begin
                    t_rot_result want;
                    want = expected_rots.pop_front();
                    if (o_out_x !== want.x) begin
                        $display("%0t: out_x expected %0d got %0d", $time, want.x, o_out_x);
                        error_count++;
                    end
                    if (o_out_y !== want.y) begin
                        $display("%0t: out_y expected %0d got %0d", $time, want.y, o_out_y);
                        error_count++;
                    end
                    if (o_out_z !== want.z) begin
                        $display("%0t: out_z expected %0d got %0d", $time, want.z, o_out_z);
                        error_count++;
                    end
                    if (o_degenerate !== want.deg) begin
                        $display("%0t: degenerate expected %0b got %0b", $time,
                                 want.deg, o_degenerate);
                        error_count++;
                    end
                    if (o_saturated !== want.sat) begin
                        $display("%0t: saturated expected %0b got %0b", $time,
                                 want.sat, o_saturated);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: drop the run if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Write one register and mirror it, unless the index is unused.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [QW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= REG_K)
            quat_regs[idx[1:0]] = val;
    endtask

    task automatic load_quat(input logic [QW-1:0] qs, qi, qj, qk);
        write_reg(REG_SCALAR, qs);
        write_reg(REG_I, qi);
        write_reg(REG_J, qj);
        write_reg(REG_K, qk);
    endtask

    // Hold until every item is sent and every result has come back.
    task automatic wait_drained();
        while (pending_vecs.size() > 0 || i_in_valid || expected_rots.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [VW-1:0] rand_comp();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return $urandom;
        else if (pick < 7)
            return $signed($urandom_range(1 << 21)) - (1 << 20);
        else if (pick == 7)
            return 32'sh7FFF_FFFF;
        else if (pick == 8)
            return 32'sh8000_0000;
        return $urandom_range(3) - 1;
    endfunction

    function automatic logic [QW-1:0] rand_qcomp();
        int pick;
        pick = $urandom_range(7);
        if (pick < 5)
            return QW'($urandom);
        else if (pick == 5)
            return QW'($urandom_range(7) - 3);
        else if (pick == 6)
            return 16'h8000;
        return 16'h7FFF;
    endfunction

    task automatic push_directed();
        pending_vecs.push_back('{32'sd0, 32'sd0, 32'sd0});
        pending_vecs.push_back('{32'sh0001_0000, 32'sd0, 32'sd0});
        pending_vecs.push_back('{32'sd0, 32'sh0001_0000, 32'sd0});
        pending_vecs.push_back('{32'sd0, 32'sd0, 32'sh0001_0000});
        pending_vecs.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        pending_vecs.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        pending_vecs.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
        pending_vecs.push_back('{-32'sd1, 32'sd1, -32'sd1});
        pending_vecs.push_back('{32'sh00FF_FFFF, -32'sh0100_0000, 32'sh0123_4567});
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            pending_vecs.push_back('{rand_comp(), rand_comp(), rand_comp()});
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity after reset
        push_directed();
        wait_drained();

        // unused index must leave the quaternion alone
        write_reg(REG_UNUSED, 16'h1234);
        push_directed();
        wait_drained();

        // 90 degrees about z, then zero quaternion, then extremes
        load_quat(16'sd5793, 16'sd0, 16'sd0, 16'sd5793);
        push_directed();
        wait_drained();
        load_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_directed();
        wait_drained();
        load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_directed();
        wait_drained();
        load_quat(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        push_directed();
        wait_drained();
        // tiny quaternion: normalization at the deepest scale
        load_quat(16'h0000, 16'h0001, 16'h0000, 16'h0000);
        push_directed();
        wait_drained();

        for (int phase = 0; phase < 12; phase++) begin
            if (phase < 4) begin
                send_idle_pct = 12;
                recv_idle_pct = 84;
            end else if (phase < 8) begin
                send_idle_pct = 84;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 0)
                load_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            else
                load_quat(rand_qcomp(), rand_qcomp(), rand_qcomp(), rand_qcomp());
            push_random(70);
            wait_drained();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
